// ===== rtl/cobs_stream_decoder_macros.svh =====
// Assertion macros shared by the COBS stream decoder RTL.
// Depends on nothing; included by cobs_dec_core, the module that carries assertions.
`ifndef COBS_STREAM_DECODER_MACROS_SVH
`define COBS_STREAM_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge outside reset.
`define COBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("COBS decoder assertion failed");
// Condition in one cycle implies a consequence in the next cycle.
`define COBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("COBS decoder assertion failed");
`else
`define COBS_ASSERT(lbl, clk, rst_n, prop)
`define COBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/cobs_dec_pkg.sv =====
// Shared types and constants of the COBS stream decoder.
// Depends on nothing; used by every module of the decoder.
package cobs_dec_pkg;

  // Largest decoded frame length before overflow is flagged.
  localparam logic [7:0] MAX_MESSAGE = 8'd254;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_CONSUMED       = 3'd0,
    ST_EMITTED        = 3'd1,
    ST_COMPLETE       = 3'd2,
    ST_UNEXPECTED_END = 3'd3,
    ST_OVERFLOW       = 3'd4
  } status_e;

  // One received byte held in the input stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  // One decoded result.
  typedef struct packed {
    status_e    status;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [7:0] message_length;
  } res_t;

endpackage

// ===== rtl/cobs_dec_in_reg.sv =====
// Input register stage of the COBS stream decoder.
// Depends on cobs_dec_pkg.
module cobs_dec_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          data_i,
  input  logic                pop_i,
  output cobs_dec_pkg::beat_t beat_o
);

  logic       valid_q;
  logic [7:0] data_q;

  // The stage takes a new beat when empty or when its beat moves on.
  assign ready_o = !valid_q || pop_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

// ===== rtl/cobs_dec_core.sv =====
// Decode logic and frame state of the COBS stream decoder.
// Depends on cobs_dec_pkg and cobs_stream_decoder_macros.svh.
`include "cobs_stream_decoder_macros.svh"
module cobs_dec_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cobs_dec_pkg::beat_t beat_i,
  input  logic                out_ready_i,
  output logic                adv_o,
  output cobs_dec_pkg::res_t  res_o
);

  logic [7:0] group_q;
  logic [7:0] group_d;
  logic [7:0] pos_q;
  logic [7:0] pos_d;
  logic       emit;
  logic [7:0] emit_data;
  logic       ends_frame;
  logic       emitted;

  // A beat is decoded when the result register can take its result.
  assign adv_o = beat_i.valid && out_ready_i;

  // Decision for one received byte.
  always_comb begin
    group_d             = group_q;
    pos_d               = pos_q;
    emit                = 1'b0;
    emit_data           = 8'd0;
    res_o.status         = cobs_dec_pkg::ST_CONSUMED;
    res_o.out_valid      = 1'b0;
    res_o.out_byte       = 8'd0;
    res_o.message_length = 8'd0;
    if (group_q != 8'd0) begin
      if (beat_i.data == 8'd0) begin
        // Zero inside a group aborts the frame.
        group_d      = 8'd0;
        pos_d        = 8'd0;
        res_o.status = cobs_dec_pkg::ST_UNEXPECTED_END;
      end else begin
        group_d   = group_q - 8'd1;
        emit      = 1'b1;
        emit_data = beat_i.data;
      end
    end else if (beat_i.data == 8'd0) begin
      // Delimiter at a code position closes the frame.
      group_d      = 8'd0;
      pos_d        = 8'd0;
      res_o.status = cobs_dec_pkg::ST_COMPLETE;
      res_o.message_length = (pos_q == 8'd0) ? 8'd0 : pos_q - 8'd1;
    end else begin
      group_d = beat_i.data - 8'd1;
      if (pos_q == 8'd0) begin
        // The first code byte of a frame restores no zero.
        pos_d = 8'd1;
      end else begin
        emit = 1'b1;
      end
    end

    // Emit a decoded byte unless the frame grows too long.
    if (emit) begin
      if (pos_q > cobs_dec_pkg::MAX_MESSAGE) begin
        group_d      = 8'd0;
        pos_d        = 8'd0;
        res_o.status = cobs_dec_pkg::ST_OVERFLOW;
      end else begin
        pos_d           = pos_q + 8'd1;
        res_o.status    = cobs_dec_pkg::ST_EMITTED;
        res_o.out_valid = 1'b1;
        res_o.out_byte  = emit_data;
      end
    end
  end

  // Frame state advances once per decoded beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 8'd0;
      pos_q   <= 8'd0;
    end else if (adv_o) begin
      group_q <= group_d;
      pos_q   <= pos_d;
    end
  end

  // Result kinds that the checks below refer to.
  assign ends_frame = (res_o.status == cobs_dec_pkg::ST_COMPLETE) ||
                      (res_o.status == cobs_dec_pkg::ST_UNEXPECTED_END) ||
                      (res_o.status == cobs_dec_pkg::ST_OVERFLOW);
  assign emitted    = (res_o.status == cobs_dec_pkg::ST_EMITTED);

  // A group is only open once the first code byte has been seen.
  `COBS_ASSERT(a_group_needs_pos, clk_i, rst_ni, (pos_q != 8'd0) || (group_q == 8'd0))
  // Terminating results leave the decoder waiting for a new frame.
  `COBS_ASSERT_NEXT(a_restart_after_end, clk_i, rst_ni, adv_o && ends_frame, (group_q == 8'd0) && (pos_q == 8'd0))
  // Each emitted byte advances the frame position by one.
  `COBS_ASSERT_NEXT(a_emit_counts, clk_i, rst_ni, adv_o && emitted, pos_q == $past(pos_q) + 8'd1)
  // The data flag goes with the emitted status only.
  `COBS_ASSERT(a_valid_status, clk_i, rst_ni, res_o.out_valid == emitted)

endmodule

// ===== rtl/cobs_dec_out_reg.sv =====
// Result register stage of the COBS stream decoder.
// Depends on cobs_dec_pkg.
module cobs_dec_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  cobs_dec_pkg::res_t res_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output cobs_dec_pkg::res_t res_o
);

  logic               valid_q;
  cobs_dec_pkg::res_t res_q;

  // Free when empty or when the held result leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/cobs_stream_decoder.sv =====
// Top level of the COBS stream decoder: input stage, decode core, result stage.
// Depends on cobs_dec_pkg, cobs_dec_in_reg, cobs_dec_core and cobs_dec_out_reg.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] in_byte
//   m_axis    out        tuser[2:0] status, tuser[3] out_valid,
//                        tdata[7:0] out_byte, tdata[15:8] message_length
//
// Every input beat yields exactly one result beat, which passes the input register
// and then the result register. One beat is accepted per cycle while the result
// register is free; the decode state is updated once per decoded beat.
// Reset is asynchronous, active low, and leaves the decoder expecting a new frame.
// A stall on m_axis holds the result register; the input stage then fills and
// s_axis_tready_o drops until the result is taken.
module cobs_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [15:8] message_length
  output logic [3:0]  m_axis_tuser_o    // [2:0] status, [3] out_valid
);

  cobs_dec_pkg::beat_t beat;
  cobs_dec_pkg::res_t  res_d;
  cobs_dec_pkg::res_t  res_q;
  logic                adv;
  logic                out_ready;

  cobs_dec_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .pop_i   (adv),
    .beat_o  (beat)
  );

  cobs_dec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .out_ready_i (out_ready),
    .adv_o       (adv),
    .res_o       (res_d)
  );

  cobs_dec_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (res_d),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_q)
  );

  // Pack the result beat.
  assign m_axis_tdata_o = {res_q.message_length, res_q.out_byte};
  assign m_axis_tuser_o = {res_q.out_valid, res_q.status};

endmodule
